/* rtl/sfws_pkg.sv */
package sfws_pkg;

	// pair addressing reaches 65535 + 255*511 + 255, which fits 18 bits
	localparam int ADDR_W = 18;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index is the word address, paddr[2]
	localparam logic REG_NUM_LABELS = 1'b0;

	localparam logic [8:0] NUM_LABELS_RST = 9'd1;

	localparam logic [31:0] SCORE_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SCORE_MIN = 32'h8000_0000;

	typedef struct packed {
		logic term;
		logic in_range;
		logic binary;
		logic contrib;
		logic last;
	} term_ctl_t;

endpackage

/* rtl/sfws_wmem.sv */
module sfws_wmem #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 32,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/sfws_mac.sv */
module sfws_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_s2,
	input  sfws_pkg::term_ctl_t   ctl_s2,
	input  logic signed [31:0]    weight_s2,
	input  logic signed [31:0]    value_s2,
	input  logic                  out_stall,
	output logic                  hold,
	output logic                  out_valid,
	output logic [31:0]           score,
	output logic                  range_error
);

	logic                v_s3;
	sfws_pkg::term_ctl_t ctl_s3;
	logic signed [31:0]  w_s3;
	logic signed [63:0]  prod_s3;

	logic                res_s4;
	logic [63:0]         sum_s4;
	logic                err_s4;

	logic [63:0]         acc_q;
	logic                err_q;

	logic                out_valid_q;
	logic [31:0]         score_q;
	logic                range_error_q;

	logic [63:0]         add_s3;
	logic [63:0]         acc_next;
	logic                err_next;
	logic                out_load;
	logic                close_s3;
	logic [31:0]         sat_score;

	// output slot frees up when empty or being taken
	assign out_load = !out_valid_q || !out_stall;
	// only a pending score that cannot move freezes the pipe
	assign hold     = res_s4 && !out_load;
	assign close_s3 = v_s3 && ctl_s3.term && ctl_s3.last;

	always_comb begin
		if (ctl_s3.binary) begin
			add_s3 = {{32{w_s3[31]}}, w_s3};
		end else begin
			add_s3 = {{16{prod_s3[63]}}, prod_s3[63:16]};
		end
		if (v_s3 && ctl_s3.term && ctl_s3.contrib && ctl_s3.in_range) begin
			acc_next = acc_q + add_s3;
		end else begin
			acc_next = acc_q;
		end
		err_next = err_q | (v_s3 && ctl_s3.term && ctl_s3.contrib && !ctl_s3.in_range);
	end

	always_comb begin
		if (sum_s4[63:31] == '0 || sum_s4[63:31] == '1) begin
			sat_score = sum_s4[31:0];
		end else if (sum_s4[63]) begin
			sat_score = sfws_pkg::SCORE_MIN;
		end else begin
			sat_score = sfws_pkg::SCORE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			res_s4 <= 1'b0;
			acc_q  <= '0;
			err_q  <= 1'b0;
		end else if (!hold) begin
			v_s3   <= v_s2 && ctl_s2.term;
			res_s4 <= close_s3;
			if (close_s3) begin
				acc_q <= '0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				err_q <= err_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			ctl_s3  <= ctl_s2;
			w_s3    <= weight_s2;
			prod_s3 <= weight_s2 * value_s2;
			sum_s4  <= acc_next;
			err_s4  <= err_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= res_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			score_q       <= sat_score;
			range_error_q <= err_s4;
		end
	end

	assign out_valid   = out_valid_q;
	assign score       = score_q;
	assign range_error = range_error_q;

`ifndef NO_ASSERTIONS
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(close_s3 && !hold) |=> (acc_q == '0 && !err_q))
		else $error("accumulator not cleared after score");

	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_s4))
		else $error("score word appeared without a closed list");

	a_err_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> $past(v_s3 && ctl_s3.term && ctl_s3.contrib && !ctl_s3.in_range))
		else $error("range error set without an out of range term");

	a_hold_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> (res_s4 && $stable(sum_s4)))
		else $error("pending score lost while stalled");
`endif

endmodule

/* rtl/sparse_feature_weight_score.sv */
// channel | handshake             | word
// in      | in_valid / in_stall   | mode, table_select, base_index, pair_addressing, label,
//         |                       | right_label, term_value, is_binary, contributes, last
// out     | out_valid / out_stall | score, range_error
// cfg     | apb write/read        | num_labels at byte address 0
//
// one word accepted per cycle while in_stall is low; a score is registered on out after its last term has been taken
// the rate is set by the single port of each weight memory, one access per word
// stages: address, memory read, multiply, accumulate, output register
// in_stall rises only when a finished score waits in stage 4 behind a stalled output word
// reset clears the accumulator and the error flag and sets num_labels to 1; weights are kept
module sparse_feature_weight_score #(
	parameter int FEATURE_DEPTH    = 65536,
	parameter int CONSTRAINT_DEPTH = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfws_pkg::PADDR_W-1:0]  paddr,
	input  logic [sfws_pkg::PDATA_W-1:0]  pwdata,
	output logic [sfws_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic                          table_select,
	input  logic [15:0]                   base_index,
	input  logic                          pair_addressing,
	input  logic [7:0]                    label,
	input  logic [7:0]                    right_label,
	input  logic signed [31:0]            term_value,
	input  logic                          is_binary,
	input  logic                          contributes,
	input  logic                          last,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            score,
	output logic                          range_error
);

	localparam int FAW  = $clog2(FEATURE_DEPTH);
	localparam int CAW  = $clog2(CONSTRAINT_DEPTH);
	localparam int MAW  = (FAW > CAW) ? FAW : CAW;
	localparam int AW   = (MAW > sfws_pkg::ADDR_W) ? MAW : sfws_pkg::ADDR_W;

	logic [8:0]          num_labels_q;

	logic                hold;
	logic                in_accept;

	logic [16:0]         lab_prod;
	logic [AW-1:0]       offset;
	logic [AW-1:0]       addr;
	logic                in_range;

	logic                v_s1;
	logic                tsel_s1;
	logic [AW-1:0]       addr_s1;
	logic signed [31:0]  value_s1;
	sfws_pkg::term_ctl_t ctl_s1;

	logic                v_s2;
	logic                tsel_s2;
	logic signed [31:0]  value_s2;
	sfws_pkg::term_ctl_t ctl_s2;

	logic [31:0]         f_rdata;
	logic [31:0]         c_rdata;
	logic signed [31:0]  weight_s2;
	logic                f_we;
	logic                c_we;

	// config port
	assign pready = 1'b1;
	assign prdata = sfws_pkg::PDATA_W'(num_labels_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_labels_q <= sfws_pkg::NUM_LABELS_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == sfws_pkg::REG_NUM_LABELS) begin
			num_labels_q <= pwdata[8:0];
		end
	end

	assign in_stall  = hold;
	assign in_accept = in_valid && !hold;

	// table address; writes use the raw index
	always_comb begin
		lab_prod = 17'(label) * 17'(num_labels_q);
		if (pair_addressing) begin
			offset = AW'(lab_prod) + AW'(right_label);
		end else begin
			offset = AW'(label);
		end
		if (mode) begin
			addr = AW'(base_index) + offset;
		end else begin
			addr = AW'(base_index);
		end
		if (table_select) begin
			in_range = {1'b0, addr} < (AW + 1)'(CONSTRAINT_DEPTH);
		end else begin
			in_range = {1'b0, addr} < (AW + 1)'(FEATURE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!hold) begin
			v_s1 <= in_accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			tsel_s1        <= table_select;
			addr_s1        <= addr;
			value_s1       <= term_value;
			ctl_s1.term    <= mode;
			ctl_s1.in_range <= in_range;
			ctl_s1.binary  <= is_binary;
			ctl_s1.contrib <= contributes;
			ctl_s1.last    <= last;

			tsel_s2  <= tsel_s1;
			value_s2 <= value_s1;
			ctl_s2   <= ctl_s1;
		end
	end

	// writes and reads both issue from stage 1, so program order is kept
	assign f_we = !hold && v_s1 && !ctl_s1.term && ctl_s1.in_range && !tsel_s1;
	assign c_we = !hold && v_s1 && !ctl_s1.term && ctl_s1.in_range && tsel_s1;

	sfws_wmem #(
		.DEPTH (FEATURE_DEPTH),
		.WIDTH (32)
	) u_feature_mem (
		.clk   (clk),
		.we    (f_we),
		.re    (!hold),
		.addr  (addr_s1[FAW-1:0]),
		.wdata (value_s1),
		.rdata (f_rdata)
	);

	sfws_wmem #(
		.DEPTH (CONSTRAINT_DEPTH),
		.WIDTH (32)
	) u_constraint_mem (
		.clk   (clk),
		.we    (c_we),
		.re    (!hold),
		.addr  (addr_s1[CAW-1:0]),
		.wdata (value_s1),
		.rdata (c_rdata)
	);

	assign weight_s2 = tsel_s2 ? c_rdata : f_rdata;

	sfws_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s2        (v_s2),
		.ctl_s2      (ctl_s2),
		.weight_s2   (weight_s2),
		.value_s2    (value_s2),
		.out_stall   (out_stall),
		.hold        (hold),
		.out_valid   (out_valid),
		.score       (score),
		.range_error (range_error)
	);

endmodule
